FILE: hw/rtl/lru_key_tracker_unit_defines.svh
// assertion macros used by the lru key tracker rtl
`ifndef LRU_KEY_TRACKER_UNIT_DEFINES_SVH
`define LRU_KEY_TRACKER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// expression holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/lkt_pkg.sv
`default_nettype none

package lkt_pkg;

    localparam int KEY_W = 64;
    localparam int OCC_W = 5;

    localparam logic OP_TOUCH = 1'b0;
    localparam logic OP_EVICT = 1'b1;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic en;
        logic evict;
        logic hit_any;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: hw/rtl/lkt_cell.sv
`default_nettype none

module lkt_cell #(
    parameter int KEY_BITS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire lkt_pkg::t_cell_ctl    i_ctl,
    input  wire logic [KEY_BITS-1:0]   i_key,
    input  wire logic [KEY_BITS-1:0]   i_next_key,
    input  wire logic                  i_next_valid,
    input  wire logic                  i_prev_valid,
    input  wire logic                  i_seen,
    output logic [KEY_BITS-1:0]        o_key,
    output logic                       o_valid,
    output logic                       o_match,
    output logic                       o_seen
);
    import lkt_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    logic                r_valid;
    logic [KEY_BITS-1:0] n_key;
    logic                n_valid;
    logic                w_match;
    logic                w_seen;

    assign w_match = r_valid && (r_key == i_key);
    // at or after the hit slot in the age order
    assign w_seen  = i_seen | w_match;

    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_ctl.evict) begin
            n_key   = i_next_key;
            n_valid = i_next_valid;
        end else if (i_ctl.hit_any) begin
            if (w_seen && r_valid) begin
                n_key = i_next_valid ? i_next_key : i_key;
            end
        end else if (!r_valid && i_prev_valid) begin
            // first free slot takes the new key, none when full
            n_key   = i_key;
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_key <= n_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= n_valid;
        end
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;
    assign o_match = w_match;
    assign o_seen  = w_seen;

endmodule

`default_nettype wire

FILE: hw/rtl/lru_key_tracker_unit.sv
// the result of an accepted item is registered and valid in the next cycle
// throughput: one item per cycle unless an unread result stalls o_ready; every cell
// compares and shifts in the same cycle, so the row compare and neighbor shift set it
// reset: synchronous active low, clears the valid bit of each cell, the count
// and the result valid flag; stored keys and result fields need no clearing pass
`default_nettype none
`include "lru_key_tracker_unit_defines.svh"

module lru_key_tracker_unit #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_op,
    input  wire logic [lkt_pkg::KEY_W-1:0]  i_key,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [lkt_pkg::KEY_W-1:0]       o_evicted_key,
    output logic                            o_evict_done,
    output logic                            o_was_present,
    output logic                            o_full_reject,
    output logic [lkt_pkg::OCC_W-1:0]       o_occupancy
);
    import lkt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    logic [KEY_W-1:0]    r_evicted_key;
    logic                r_evict_done;
    logic                r_was_present;
    logic                r_full_reject;

    logic                w_accept;
    logic                w_evict;
    logic                w_empty;
    logic                w_full;
    logic                w_hit;
    logic [KEY_BITS-1:0] w_in_key;
    t_cell_ctl           w_ctl;

    logic [KEY_BITS-1:0] w_key   [CAPACITY+1];
    logic                w_vld   [CAPACITY+1];
    logic                w_seen  [CAPACITY+1];
    logic [CAPACITY-1:0] w_valid_vec;
    logic [CAPACITY-1:0] w_match_vec;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_evict  = (i_op == OP_EVICT);
    assign w_in_key = i_key[KEY_BITS-1:0];
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_hit    = w_seen[CAPACITY];

    assign w_ctl.en      = w_accept;
    assign w_ctl.evict   = w_evict;
    assign w_ctl.hit_any = w_hit;

    // row ends: nothing past the newest slot, an always-valid slot before the oldest
    assign w_key[CAPACITY] = '0;
    assign w_vld[CAPACITY] = 1'b0;
    assign w_seen[0]       = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic w_prev;
        logic w_seen_out;

        if (g == 0) begin : g_first
            assign w_prev = 1'b1;
        end else begin : g_rest
            assign w_prev = w_vld[g-1];
        end

        lkt_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key        (w_in_key),
            .i_next_key   (w_key[g+1]),
            .i_next_valid (w_vld[g+1]),
            .i_prev_valid (w_prev),
            .i_seen       (w_seen[g]),
            .o_key        (w_key[g]),
            .o_valid      (w_vld[g]),
            .o_match      (w_match_vec[g]),
            .o_seen       (w_seen_out)
        );

        assign w_seen[g+1]    = w_seen_out;
        assign w_valid_vec[g] = w_vld[g];
    end

    always_comb begin
        n_count = r_count;
        if (w_evict) begin
            if (!w_empty) begin
                n_count = r_count - CNT_W'(1);
            end
        end else if (!w_hit && !w_full) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_evicted_key <= (w_evict && !w_empty) ? KEY_W'(w_key[0]) : '0;
            r_evict_done  <= w_evict && !w_empty;
            r_was_present <= !w_evict && w_hit;
            r_full_reject <= !w_evict && !w_hit && w_full;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_evicted_key = r_evicted_key;
    assign o_evict_done  = r_evict_done;
    assign o_was_present = r_was_present;
    assign o_full_reject = r_full_reject;
    assign o_occupancy   = OCC_W'(r_count);

    // valid bits stay packed at the old end and agree with the count
    `ASSERT_ALWAYS(a_valid_count, i_clk, i_rst_n,
        $countones(w_valid_vec) == int'(r_count))
    // stored keys are unique, so a touch hits at most one cell
    `ASSERT_ALWAYS(a_single_hit, i_clk, i_rst_n, $onehot0(w_match_vec))
    // a refused key leaves a full set behind
    `ASSERT_IMPLIES(a_reject_full, i_clk, i_rst_n,
        r_out_valid && r_full_reject, r_count == CNT_W'(CAPACITY))
    // a successful evict drops the count by one
    `ASSERT_NEXT(a_evict_count, i_clk, i_rst_n,
        w_accept && w_evict && !w_empty, r_count == $past(r_count) - CNT_W'(1))

endmodule

`default_nettype wire

FILE: verif/lru_key_tracker_unit_test.sv
`timescale 1ns / 100ps

module lru_key_tracker_unit_test;

    import lkt_pkg::*;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 64;
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
    localparam int STALL_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int POOL_SIZE = 24;

    typedef struct packed {
        logic [KEY_W-1:0] evicted_key;
        logic             evict_done;
        logic             was_present;
        logic             full_reject;
        logic [OCC_W-1:0] occupancy;
    } t_lru_reply;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
        logic             typed;
        t_lru_reply       reply;
    } t_vector;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic             i_op = OP_TOUCH;
    logic [KEY_W-1:0] i_key = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [KEY_W-1:0] o_evicted_key;
    logic             o_evict_done;
    logic             o_was_present;
    logic             o_full_reject;
    logic [OCC_W-1:0] o_occupancy;

    // shadow of the recency list, slot 0 is least recent
    logic [KEY_W-1:0] lru_order [CAPACITY];
    int               lru_fill = 0;

    t_lru_reply replies_due [$];
    int         errors = 0;
    int         replies_seen = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    int n_touches = 0;
    int n_hits = 0;
    int n_rejects = 0;
    int n_evicts = 0;
    int n_empty_evicts = 0;

    lru_key_tracker_unit #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_op(i_op),
        .i_key(i_key),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_evicted_key(o_evicted_key),
        .o_evict_done(o_evict_done),
        .o_was_present(o_was_present),
        .o_full_reject(o_full_reject),
        .o_occupancy(o_occupancy)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_lru_reply lru_access(input logic op, input logic [KEY_W-1:0] key);
        t_lru_reply r;
        logic [KEY_W-1:0] k;
        int hit_at;
        r = '0;
        k = key & KEY_MASK;
        hit_at = -1;
        if (op == OP_EVICT) begin
            n_evicts++;
            if (lru_fill == 0) begin
                n_empty_evicts++;
            end else begin
                r.evicted_key = lru_order[0] & KEY_MASK;
                r.evict_done = 1'b1;
                for (int i = 0; i + 1 < lru_fill; i++)
                    lru_order[i] = lru_order[i + 1];
                lru_fill--;
            end
        end else begin
            n_touches++;
            for (int i = 0; i < lru_fill; i++)
                if (hit_at < 0 && lru_order[i] == k)
                    hit_at = i;
            if (hit_at >= 0) begin
                // move the hit to the most recent slot
                for (int j = hit_at; j + 1 < lru_fill; j++)
                    lru_order[j] = lru_order[j + 1];
                lru_order[lru_fill - 1] = k;
                r.was_present = 1'b1;
                n_hits++;
            end else if (lru_fill >= CAPACITY) begin
                r.full_reject = 1'b1;
                n_rejects++;
            end else begin
                lru_order[lru_fill] = k;
                lru_fill++;
            end
        end
        r.occupancy = lru_fill[OCC_W-1:0];
        return r;
    endfunction

    function automatic t_vector row(input logic op, input logic [KEY_W-1:0] key,
                                    input logic typed, input logic [KEY_W-1:0] ek,
                                    input logic done, input logic present,
                                    input logic reject, input int occ);
        t_vector v;
        v.op = op;
        v.key = key;
        v.typed = typed;
        v.reply.evicted_key = ek;
        v.reply.evict_done = done;
        v.reply.was_present = present;
        v.reply.full_reject = reject;
        v.reply.occupancy = occ[OCC_W-1:0];
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40)
            $display("mismatch at reply %0d: %s", replies_seen, what);
    endtask

    // drive one item, hold it until accepted, then record what must come back
    task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                             input logic typed, input t_lru_reply typed_reply);
        t_lru_reply predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_key <= key;
        do @(posedge i_clk); while (!o_ready);
        predicted = lru_access(op, key);
        replies_due.push_back(typed ? typed_reply : predicted);
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            replies_seen++;
            if (replies_due.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, key %h", o_evicted_key));
            end else begin
                t_lru_reply want;
                want = replies_due.pop_front();
                if (o_evicted_key !== want.evicted_key)
                    report_mismatch($sformatf("evicted_key %h, expected %h",
                                              o_evicted_key, want.evicted_key));
                if (o_evict_done !== want.evict_done)
                    report_mismatch($sformatf("evict_done %b, expected %b",
                                              o_evict_done, want.evict_done));
                if (o_was_present !== want.was_present)
                    report_mismatch($sformatf("was_present %b, expected %b",
                                              o_was_present, want.was_present));
                if (o_full_reject !== want.full_reject)
                    report_mismatch($sformatf("full_reject %b, expected %b",
                                              o_full_reject, want.full_reject));
                if (o_occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy %0d, expected %0d",
                                              o_occupancy, want.occupancy));
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("lru_key_tracker_unit test failed");
        $finish;
    end

    initial begin : stimulus
        t_vector          dir_rows [25];
        logic [KEY_W-1:0] key_pool [POOL_SIZE];
        logic [KEY_W-1:0] key;
        logic             op;
        logic             draining;
        int               pick;
        int               evict_pct;

        dir_rows[0] = row(OP_EVICT, '0, 1'b1, '0, 1'b0, 1'b0, 1'b0, 0);
        dir_rows[1] = row(OP_TOUCH, '0, 1'b1, '0, 1'b0, 1'b0, 1'b0, 1);
        dir_rows[2] = row(OP_TOUCH, '1, 1'b1, '0, 1'b0, 1'b0, 1'b0, 2);
        dir_rows[3] = row(OP_TOUCH, '0, 1'b1, '0, 1'b0, 1'b1, 1'b0, 2);
        dir_rows[4] = row(OP_EVICT, '0, 1'b1, '1 & KEY_MASK, 1'b1, 1'b0, 1'b0, 1);
        // fill up to capacity behind key zero
        for (int i = 0; i < 15; i++)
            dir_rows[5 + i] = row(OP_TOUCH, 64'hA5A5_0000_0000_0000 | (64'h1 << (i * 3)),
                                  1'b0, '0, 1'b0, 1'b0, 1'b0, 0);
        dir_rows[20] = row(OP_TOUCH, 64'h5555_5555_5555_5555, 1'b1,
                           '0, 1'b0, 1'b0, 1'b1, CAPACITY);
        // stored key into a full set moves, no refusal
        dir_rows[21] = row(OP_TOUCH, '0, 1'b1, '0, 1'b0, 1'b1, 1'b0, CAPACITY);
        dir_rows[22] = row(OP_EVICT, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);
        dir_rows[23] = row(OP_TOUCH, 64'h5555_5555_5555_5555, 1'b0,
                           '0, 1'b0, 1'b0, 1'b0, 0);
        // key field is don't care on evict
        dir_rows[24] = row(OP_EVICT, '1, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);

        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};
        draining = 1'b0;

        send_idle_pct = 11;
        recv_stall_pct = 88;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_item(dir_rows[r].op, dir_rows[r].key, dir_rows[r].typed, dir_rows[r].reply);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 88 : 0;
            recv_stall_pct = (phase == 0) ? 88 : (phase == 1) ? 11 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // fill and drain stretches, chosen at random, so the set swings empty to full
                if (n % 40 == 0)
                    draining = $urandom_range(0, 1);
                evict_pct = draining ? 65 : 15;
                op = ($urandom_range(0, 99) < evict_pct) ? OP_EVICT : OP_TOUCH;
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                end else if (pick < 80) begin
                    // near miss on a pooled key
                    key = key_pool[$urandom_range(0, POOL_SIZE - 1)]
                          ^ (64'h1 << $urandom_range(0, KEY_W - 1));
                end else begin
                    key = {$urandom, $urandom};
                    key_pool[$urandom_range(0, POOL_SIZE - 1)] = key;
                end
                send_item(op, key, 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (replies_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", replies_due.size()));

        $display("ran %0d touches (%0d hits, %0d refused on a full set) and %0d evicts",
                 n_touches, n_hits, n_rejects, n_evicts);
        $display("%0d evicts found the set empty, %0d results checked, %0d mismatches",
                 n_empty_evicts, replies_seen, errors);
        if (errors == 0) begin
            $display("lru_key_tracker_unit test passed");
        end else begin
            $display("lru_key_tracker_unit test failed");
        end
        $finish;
    end

endmodule
